// ----- rtl/fingertip_key_press_detector_defines.svh -----
// Assertion macros for the fingertip key-press detector checker.
// Expect clk_i and rst_ni in the scope of use.
`ifndef FINGERTIP_KEY_PRESS_DETECTOR_DEFINES_SVH
`define FINGERTIP_KEY_PRESS_DETECTOR_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define FKP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define FKP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/fkp_pkg.sv -----
// Shared types, constants and key tables for the fingertip key-press detector.
// No dependencies.
package fkp_pkg;

  localparam int COORD_BITS = 10;
  localparam int THR_BITS   = COORD_BITS + 1;
  localparam int ZONE_BITS  = COORD_BITS - 3;
  localparam int DIV3_MUL   = 171;
  localparam int DIV3_SHIFT = 9;
  localparam int CNT_BITS   = 8;
  localparam int NOTE_BITS  = 4;
  localparam int IDX_BITS   = 3;
  localparam int IN_BYTES   = (2 * COORD_BITS + 7) / 8;
  localparam int IN_W       = 8 * IN_BYTES;
  localparam int OUT_W      = 8;
  localparam int N_WHITE    = 8;
  localparam int N_BLACK    = 5;

  localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

  typedef enum logic [IDX_BITS-1:0] {
    REG_FRAME_WIDTH    = 3'd0,
    REG_DESCEND_STEP   = 3'd1,
    REG_WHITE_ROW_MIN  = 3'd2,
    REG_BLACK_ROW_LOW  = 3'd3,
    REG_BLACK_ROW_HIGH = 3'd4,
    REG_DWELL_FRAMES   = 3'd5
  } cfg_reg_e;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t              frame_width;
    coord_t              descend_step;
    coord_t              white_row_min;
    coord_t              black_row_low;
    coord_t              black_row_high;
    logic [CNT_BITS-1:0] dwell_frames;
  } cfg_t;

  typedef struct packed {
    logic descending;
    logic white_press;
    logic black_press;
  } motion_t;

  typedef logic [NOTE_BITS-1:0] note_t;

  localparam note_t WHITE_NOTES [N_WHITE] = '{
    4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11, 4'd12
  };
  localparam logic [4:0] BLACK_LO [N_BLACK] = '{5'd2, 5'd5, 5'd11, 5'd14, 5'd17};
  localparam logic [4:0] BLACK_HI [N_BLACK] = '{5'd3, 5'd6, 5'd12, 5'd15, 5'd18};
  localparam logic [3:0] BLACK_EXTRA [N_BLACK] = '{4'd0, 4'd0, 4'd0, 4'd10, 4'd0};
  localparam note_t BLACK_NOTES [N_BLACK] = '{4'd1, 4'd3, 4'd6, 4'd8, 4'd10};

endpackage

// ----- rtl/fkp_cfg_regs.sv -----
// Configuration register file of the fingertip key-press detector.
// Depends on fkp_pkg.
module fkp_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_en_i,
  input  logic [fkp_pkg::IDX_BITS-1:0] wr_index_i,
  input  fkp_pkg::coord_t             wr_data_i,
  output fkp_pkg::cfg_t               cfg_o
);
  import fkp_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (cfg_reg_e'(wr_index_i))
        REG_FRAME_WIDTH:    cfg_d.frame_width    = wr_data_i;
        REG_DESCEND_STEP:   cfg_d.descend_step   = wr_data_i;
        REG_WHITE_ROW_MIN:  cfg_d.white_row_min  = wr_data_i;
        REG_BLACK_ROW_LOW:  cfg_d.black_row_low  = wr_data_i;
        REG_BLACK_ROW_HIGH: cfg_d.black_row_high = wr_data_i;
        REG_DWELL_FRAMES:   cfg_d.dwell_frames   = wr_data_i[CNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width    <= COORD_BITS'(480);
      cfg_q.descend_step   <= COORD_BITS'(4);
      cfg_q.white_row_min  <= COORD_BITS'(210);
      cfg_q.black_row_low  <= COORD_BITS'(90);
      cfg_q.black_row_high <= COORD_BITS'(140);
      cfg_q.dwell_frames   <= CNT_BITS'(3);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/fkp_motion.sv -----
// Descent tracking and band dwell counters; gives the press conditions.
// Depends on fkp_pkg.
module fkp_motion (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  fkp_pkg::coord_t tip_y_i,
  input  fkp_pkg::cfg_t   cfg_i,
  output fkp_pkg::motion_t motion_o
);
  import fkp_pkg::*;

  coord_t              last_row_q, last_row_d;
  logic                down_q, down_d;
  logic [CNT_BITS-1:0] white_cnt_q, white_cnt_d;
  logic [CNT_BITS-1:0] black_cnt_q, black_cnt_d;
  logic [THR_BITS-1:0] rise_lim;
  logic                in_white, in_black;

  always_comb begin
    rise_lim = {1'b0, last_row_q} + {1'b0, cfg_i.descend_step};
    if ({1'b0, tip_y_i} > rise_lim) begin
      down_d = 1'b1;
    end else if (tip_y_i < last_row_q) begin
      down_d = 1'b0;
    end else begin
      down_d = down_q;
    end

    in_white = tip_y_i > cfg_i.white_row_min;
    in_black = (tip_y_i >= cfg_i.black_row_low) && (tip_y_i <= cfg_i.black_row_high);

    if (!in_white) white_cnt_d = '0;
    else if (white_cnt_q == CNT_MAX) white_cnt_d = white_cnt_q;
    else white_cnt_d = white_cnt_q + 1'b1;

    if (!in_black) black_cnt_d = '0;
    else if (black_cnt_q == CNT_MAX) black_cnt_d = black_cnt_q;
    else black_cnt_d = black_cnt_q + 1'b1;

    last_row_d = tip_y_i;

    motion_o.descending  = down_d;
    motion_o.white_press = (white_cnt_d > cfg_i.dwell_frames) && down_d;
    motion_o.black_press = (black_cnt_d > cfg_i.dwell_frames) && down_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_row_q  <= '0;
      down_q      <= 1'b0;
      white_cnt_q <= '0;
      black_cnt_q <= '0;
    end else if (step_i) begin
      last_row_q  <= last_row_d;
      down_q      <= down_d;
      white_cnt_q <= white_cnt_d;
      black_cnt_q <= black_cnt_d;
    end
  end

endmodule

// ----- rtl/fkp_key_map.sv -----
// Maps the fingertip column to a note: white zones first, then black windows.
// Depends on fkp_pkg.
module fkp_key_map (
  input  fkp_pkg::coord_t  tip_x_i,
  input  fkp_pkg::coord_t  frame_width_i,
  input  fkp_pkg::motion_t motion_i,
  output logic             key_valid_o,
  output fkp_pkg::note_t   key_note_o
);
  import fkp_pkg::*;

  localparam int PROD_BITS = ZONE_BITS + 8;
  localparam int WIN_BITS  = PROD_BITS - DIV3_SHIFT;

  logic [ZONE_BITS-1:0] zone_w;
  logic [PROD_BITS-1:0] div3_prod;
  logic [WIN_BITS-1:0]  win_w;
  logic [THR_BITS-1:0]  x_ext;
  logic [THR_BITS-1:0]  thr, lo, hi;
  logic                 white_hit, black_hit;
  note_t                white_note, black_note;

  always_comb begin
    // width/24 as (width/8)/3, reciprocal multiply exact below 512
    zone_w    = frame_width_i[COORD_BITS-1:3];
    div3_prod = PROD_BITS'(zone_w) * PROD_BITS'(DIV3_MUL);
    win_w     = div3_prod[PROD_BITS-1:DIV3_SHIFT];
    x_ext     = {1'b0, tip_x_i};

    white_hit  = 1'b0;
    white_note = '0;
    thr        = '0;
    for (int k = 0; k < N_WHITE; k++) begin
      thr = THR_BITS'(zone_w) * THR_BITS'(k + 1);
      if (!white_hit && (x_ext < thr)) begin
        white_hit  = 1'b1;
        white_note = WHITE_NOTES[k];
      end
    end

    black_hit  = 1'b0;
    black_note = '0;
    lo         = '0;
    hi         = '0;
    for (int k = 0; k < N_BLACK; k++) begin
      lo = THR_BITS'(win_w) * THR_BITS'(BLACK_LO[k]);
      hi = THR_BITS'(win_w) * THR_BITS'(BLACK_HI[k]) + THR_BITS'(BLACK_EXTRA[k]);
      if (!black_hit && (x_ext >= lo) && (x_ext <= hi)) begin
        black_hit  = 1'b1;
        black_note = BLACK_NOTES[k];
      end
    end

    if (motion_i.white_press && white_hit) begin
      key_valid_o = 1'b1;
      key_note_o  = white_note;
    end else if (motion_i.black_press && black_hit) begin
      key_valid_o = 1'b1;
      key_note_o  = black_note;
    end else begin
      key_valid_o = 1'b0;
      key_note_o  = '0;
    end
  end

endmodule

// ----- rtl/fingertip_key_press_detector.sv -----
// Fingertip key-press detector: input register, one pass of logic, result register.
// A taken beat waits in the input register, then passes the logic into the result register.
// Throughput: one beat per cycle; the result register stalls only on m_axis_tready.
// Reset clears the pipeline valids, the motion state and loads the register defaults.
// Depends on fkp_pkg, fkp_cfg_regs, fkp_motion and fkp_key_map.
module fingertip_key_press_detector (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [fkp_pkg::IN_W-1:0]      s_axis_tdata,  // tip_x, tip_y, zero pad
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // key_valid, key_note[3:0], white_press, black_press, descending
  output logic [fkp_pkg::OUT_W-1:0]     m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fkp_pkg::IDX_BITS-1:0]  cfg_index_i,
  input  fkp_pkg::coord_t               cfg_data_i
);
  import fkp_pkg::*;

  logic   in_vld_q;
  coord_t tip_x_q, tip_y_q;
  logic   out_vld_q;
  logic [OUT_W-1:0] out_data_q, out_data_d;
  logic   out_free, advance;
  cfg_t    cfg;
  motion_t motion;
  logic    key_valid;
  note_t   key_note;

  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_vld_q || m_axis_tready;
  assign advance       = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || out_free;

  fkp_cfg_regs u_cfg_regs (
    .clk_i,
    .rst_ni,
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  fkp_motion u_motion (
    .clk_i,
    .rst_ni,
    .step_i   (advance),
    .tip_y_i  (tip_y_q),
    .cfg_i    (cfg),
    .motion_o (motion)
  );

  fkp_key_map u_key_map (
    .tip_x_i       (tip_x_q),
    .frame_width_i (cfg.frame_width),
    .motion_i      (motion),
    .key_valid_o   (key_valid),
    .key_note_o    (key_note)
  );

  assign out_data_d = {motion.descending, motion.black_press, motion.white_press,
                       key_note, key_valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_vld_q <= s_axis_tvalid;
      if (out_free) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      tip_x_q <= s_axis_tdata[COORD_BITS-1:0];
      tip_y_q <= s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    end
    if (advance) out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ----- rtl/fkp_checker.sv -----
// Port-level checks on the result stream of the fingertip key-press detector.
// Depends on fkp_pkg and fingertip_key_press_detector_defines.svh; bound to the top level.
`include "fingertip_key_press_detector_defines.svh"

module fkp_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [fkp_pkg::OUT_W-1:0] m_axis_tdata
);
  import fkp_pkg::*;

  logic  key_valid, white_press, black_press, descending;
  note_t key_note;

  assign key_valid   = m_axis_tdata[0];
  assign key_note    = m_axis_tdata[4:1];
  assign white_press = m_axis_tdata[5];
  assign black_press = m_axis_tdata[6];
  assign descending  = m_axis_tdata[7];

  `FKP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")
  `FKP_ASSERT_IMPL(a_key_needs_press, m_axis_tvalid && key_valid, white_press || black_press, "key without a press condition")
  `FKP_ASSERT_IMPL(a_no_key_note_zero, m_axis_tvalid && !key_valid, key_note == '0, "note set without a key")
  `FKP_ASSERT_IMPL(a_note_range, m_axis_tvalid && key_valid, key_note <= note_t'(12), "note out of range")
  `FKP_ASSERT_IMPL(a_press_needs_down, m_axis_tvalid && (white_press || black_press), descending, "press while not descending")

endmodule

bind fingertip_key_press_detector fkp_checker u_fkp_checker (.*);

// ----- test/tb_fingertip_key_press_detector.sv -----
// Self-checking bench for fingertip_key_press_detector: fingertip beats go in, key beats
// are predicted and checked field by field. Several register settings are exercised.
// Depends on fkp_pkg and the detector RTL.
module tb_fingertip_key_press_detector;
  import fkp_pkg::*;

  localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
  localparam int STALL_LIMIT = 4000;

  localparam logic [IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

  localparam int NATURAL_NOTE [8] = '{0, 2, 4, 5, 7, 9, 11, 12};
  localparam int SHARP_LO     [5] = '{2, 5, 11, 14, 17};
  localparam int SHARP_HI     [5] = '{3, 6, 12, 15, 18};
  localparam int SHARP_WIDEN  [5] = '{0, 0, 0, 10, 0};
  localparam int SHARP_NOTE   [5] = '{1, 3, 6, 8, 10};

  // directed strokes at reset settings
  localparam int DIR_N = 22;
  localparam int DIR_X [DIR_N] = '{0, 1023, 1023, 100, 59, 60, 479, 480, 1023, 0, 0,
                                   40, 41, 40, 60, 61, 290, 310, 311, 360, 0, 1023};
  localparam int DIR_Y [DIR_N] = '{0, 1023, 1023, 1023, 1023, 1023, 1023, 1023, 1000, 50,
                                   100, 100, 100, 101, 102, 102, 103, 104, 104, 140, 141, 0};

  typedef struct packed {
    logic [IN_W-2*COORD_BITS-1:0] pad;
    coord_t                       tip_y;
    coord_t                       tip_x;
  } tip_beat_t;

  typedef struct packed {
    logic  descending;
    logic  black_press;
    logic  white_press;
    note_t key_note;
    logic  key_valid;
  } key_beat_t;

  logic              clk_i;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              cfg_valid_i   = 1'b0;
  logic              cfg_ready_o;
  logic [IDX_BITS-1:0] cfg_index_i = '0;
  coord_t            cfg_data_i    = '0;

  // keyboard settings as the block should hold them
  coord_t      kb_width     = 10'd480;
  coord_t      kb_step      = 10'd4;
  coord_t      kb_white_min = 10'd210;
  coord_t      kb_black_lo  = 10'd90;
  coord_t      kb_black_hi  = 10'd140;
  logic [7:0]  kb_dwell     = 8'd3;

  // finger motion as the block should track it
  coord_t      prev_row    = '0;
  logic        finger_down = 1'b0;
  logic [7:0]  white_run   = '0;
  logic [7:0]  black_run   = '0;

  tip_beat_t   pending_tips [$];
  key_beat_t   expected_keys [$];
  int          queued_tips = 0;
  bit          failed      = 1'b0;

  tip_beat_t   taken_tip;
  key_beat_t   got_key;
  key_beat_t   want_key;
  int          burst_left  = 0;
  int          gap_left    = 0;
  bit          drain_hold  = 1'b0;
  int          ready_mode  = 0;
  int          mode_left   = 0;
  int          stall_left  = 0;
  logic        ready_nxt;
  int          idle_cycles = 0;

  fingertip_key_press_detector dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  function automatic key_beat_t predict_key_beat(coord_t col, coord_t row);
    key_beat_t r;
    int        rise;
    int        z;
    int        w;
    r    = '0;
    rise = int'(row) - int'(prev_row);
    if (rise > int'(kb_step)) begin
      finger_down = 1'b1;
    end else if (rise < 0) begin
      finger_down = 1'b0;
    end
    if (row > kb_white_min) begin
      white_run = (white_run == 8'hFF) ? white_run : white_run + 8'd1;
    end else begin
      white_run = '0;
    end
    if (row >= kb_black_lo && row <= kb_black_hi) begin
      black_run = (black_run == 8'hFF) ? black_run : black_run + 8'd1;
    end else begin
      black_run = '0;
    end
    prev_row      = row;
    r.white_press = (white_run > kb_dwell) && finger_down;
    r.black_press = (black_run > kb_dwell) && finger_down;
    r.descending  = finger_down;
    z = kb_width / 8;
    w = kb_width / 24;
    if (r.white_press) begin
      for (int k = 0; k < 8; k++) begin
        if (!r.key_valid && int'(col) < z * (k + 1)) begin
          r.key_valid = 1'b1;
          r.key_note  = note_t'(NATURAL_NOTE[k]);
        end
      end
    end
    // white zone wins; first matching black window otherwise
    if (!r.key_valid && r.black_press) begin
      for (int k = 0; k < 5; k++) begin
        if (!r.key_valid && int'(col) >= w * SHARP_LO[k] &&
            int'(col) <= w * SHARP_HI[k] + SHARP_WIDEN[k]) begin
          r.key_valid = 1'b1;
          r.key_note  = note_t'(SHARP_NOTE[k]);
        end
      end
    end
    return r;
  endfunction

  function automatic int pick_col();
    int w;
    int k;
    int lo;
    int hi;
    int c;
    w = kb_width / 24;
    case ($urandom_range(0, 7))
      0: c = $urandom_range(0, COORD_MAX);
      1, 2: begin
        k  = $urandom_range(0, 4);
        lo = w * SHARP_LO[k];
        hi = w * SHARP_HI[k] + SHARP_WIDEN[k];
        case ($urandom_range(0, 3))
          0: c = lo - 1;
          1: c = lo;
          2: c = hi;
          default: c = hi + 1;
        endcase
      end
      3: begin
        k = $urandom_range(1, 8);
        c = (kb_width / 8) * k - int'($urandom_range(0, 1));
      end
      default: c = (kb_width == 0) ? 0 : $urandom_range(0, kb_width - 1);
    endcase
    if (c < 0) c = 0;
    if (c > COORD_MAX) c = COORD_MAX;
    return c;
  endfunction

  task automatic push_tip(int col, int row);
    tip_beat_t t;
    t       = '0;
    t.tip_x = coord_t'(col);
    t.tip_y = coord_t'(row);
    pending_tips.push_back(t);
    queued_tips++;
  endtask

  // approach from above the band, settle in it, optionally twitch, then lift
  task automatic queue_press(bit in_black, bit broken);
    int lo;
    int hi;
    int y;
    int d;
    int n;
    int jitter;
    if (in_black) begin
      lo = kb_black_lo;
      hi = kb_black_hi;
    end else begin
      lo = int'(kb_white_min) + 1;
      hi = COORD_MAX;
    end
    if (lo > hi) begin
      lo = 0;
      hi = COORD_MAX;
    end
    jitter = $urandom_range(0, 20);
    y = lo - int'(kb_step) - 1 - jitter;
    if (y < 0) y = 0;
    push_tip(pick_col(), y);
    y = $urandom_range(lo, (hi - lo > 40) ? lo + 40 : hi);
    push_tip(pick_col(), y);
    n = int'(kb_dwell) + $urandom_range(0, 4);
    if (n > 24) n = $urandom_range(1, 24);
    repeat (n) begin
      if (broken && $urandom_range(0, 3) == 0) begin
        jitter = $urandom_range(1, 6);
        y = (y > jitter) ? y - jitter : 0;
      end else begin
        d = $urandom_range(0, kb_step);
        if (y + d > hi) d = 0;
        y = y + d;
      end
      push_tip(pick_col(), y);
    end
    push_tip(pick_col(), $urandom_range(0, y));
  endtask

  task automatic queue_hold(int row, int n);
    push_tip(pick_col(), 0);
    repeat (n) push_tip(pick_col(), row);
  endtask

  task automatic queue_traffic(int n);
    int target;
    target = queued_tips + n;
    while (queued_tips < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: queue_press($urandom_range(0, 1), 1'b0);
        6, 7: queue_press($urandom_range(0, 1), 1'b1);
        default: begin
          repeat ($urandom_range(1, 4)) begin
            push_tip($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
          end
        end
      endcase
    end
  endtask

  task automatic write_reg(logic [IDX_BITS-1:0] idx, coord_t val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_FRAME_WIDTH:    kb_width     = val;
      REG_DESCEND_STEP:   kb_step      = val;
      REG_WHITE_ROW_MIN:  kb_white_min = val;
      REG_BLACK_ROW_LOW:  kb_black_lo  = val;
      REG_BLACK_ROW_HIGH: kb_black_hi  = val;
      REG_DWELL_FRAMES:   kb_dwell     = val[7:0];
      default: ;
    endcase
  endtask

  task automatic program_keyboard(coord_t width, coord_t step, coord_t white_min,
                                  coord_t black_lo, coord_t black_hi, coord_t dwell,
                                  bit spare);
    if (spare) begin
      write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, coord_t'($urandom));
    end
    write_reg(REG_FRAME_WIDTH, width);
    write_reg(REG_DESCEND_STEP, step);
    write_reg(REG_WHITE_ROW_MIN, white_min);
    write_reg(REG_BLACK_ROW_LOW, black_lo);
    write_reg(REG_BLACK_ROW_HIGH, black_hi);
    write_reg(REG_DWELL_FRAMES, dwell);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_for_drain();
    do @(posedge clk_i);
    while (pending_tips.size() != 0 || s_axis_tvalid || expected_keys.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      failed = 1'b1;
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // fingertip sender: bursts, gaps, and an occasional wait for all key beats
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        taken_tip = tip_beat_t'(s_axis_tdata);
        expected_keys.push_back(predict_key_beat(taken_tip.tip_x, taken_tip.tip_y));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (drain_hold) begin
          if (expected_keys.size() == 0) drain_hold = 1'b0;
          s_axis_tvalid <= 1'b0;
        end else if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_tips.size() != 0) begin
          s_axis_tdata  <= pending_tips.pop_front();
          s_axis_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            drain_hold = ($urandom_range(0, 15) == 0);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // key beat receiver: switches between stall patterns
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(32, 256);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        0: ready_nxt = 1'b1;
        1: ready_nxt = ($urandom_range(0, 3) != 0);
        2: ready_nxt = ($urandom_range(0, 3) == 0);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            ready_nxt = 1'b0;
          end else begin
            stall_left = $urandom_range(0, 16);
            ready_nxt  = 1'b1;
          end
        end
      endcase
      m_axis_tready <= ready_nxt;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_key = key_beat_t'(m_axis_tdata);
      if (expected_keys.size() == 0) begin
        $display("%0t: key beat with none expected, expected none, actual %h",
                 $time, m_axis_tdata);
        failed = 1'b1;
      end else begin
        want_key = expected_keys.pop_front();
        check_field("key_valid", want_key.key_valid, got_key.key_valid);
        check_field("key_note", want_key.key_note, got_key.key_note);
        check_field("white_press", want_key.white_press, got_key.white_press);
        check_field("black_press", want_key.black_press, got_key.black_press);
        check_field("descending", want_key.descending, got_key.descending);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_N; i++) push_tip(DIR_X[i], DIR_Y[i]);
    queue_traffic(30);
    wait_for_drain();

    // widest image, every row in the black band and every nonzero row in the white band, any growth descends
    program_keyboard(10'd1023, 10'd0, 10'd0, 10'd0, 10'd1023, 10'd0, 1'b1);
    queue_traffic(30);
    wait_for_drain();

    // narrowest legal width, overlapping bands at the last row, counter saturation
    program_keyboard(10'd24, 10'd0, 10'd1022, 10'd1023, 10'd1023, 10'd254, 1'b0);
    queue_hold(1023, 260);
    queue_traffic(10);
    wait_for_drain();

    // zero width, empty black band, dwell written with high bits set
    program_keyboard(10'd0, 10'd4, 10'd210, 10'd500, 10'd400, 10'h305, 1'b1);
    queue_traffic(30);
    wait_for_drain();

    // width below one window
    program_keyboard(10'd7, 10'd2, 10'd100, 10'd50, 10'd200, 10'd1, 1'b0);
    queue_traffic(30);
    wait_for_drain();

    // dwell of 255 never presses
    program_keyboard(10'd480, 10'd4, 10'd210, 10'd90, 10'd140, 10'd255, 1'b0);
    queue_hold(1023, 20);
    queue_traffic(20);
    wait_for_drain();

    // step too large to ever descend
    program_keyboard(10'd480, 10'd1023, 10'd210, 10'd90, 10'd140, 10'd0, 1'b0);
    queue_traffic(20);
    wait_for_drain();

    repeat (5) begin
      automatic coord_t blo = $urandom_range(0, 900);
      program_keyboard(coord_t'($urandom_range(24, COORD_MAX)),
                       coord_t'(($urandom_range(0, 3) == 0) ? $urandom_range(0, COORD_MAX)
                                                              : $urandom_range(0, 12)),
                       coord_t'($urandom_range(0, 1000)), blo,
                       coord_t'(blo + $urandom_range(0, 123)),
                       coord_t'($urandom_range(0, 6)), $urandom_range(0, 1));
      queue_traffic(20);
      wait_for_drain();
    end

    repeat (8) @(posedge clk_i);
    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/fkp_pkg.sv
rtl/fkp_cfg_regs.sv
rtl/fkp_motion.sv
rtl/fkp_key_map.sv
rtl/fingertip_key_press_detector.sv
rtl/fkp_checker.sv
test/tb_fingertip_key_press_detector.sv
